// ===== sv/mtarc_pkg.sv =====
`default_nettype none

package mtarc_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIG_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RISK_W   = 31;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [RISK_W-1:0] RISK_MAX = '1;

  localparam logic [CODE_W-1:0] OUT_IGNORED = 2'd0;
  localparam logic [CODE_W-1:0] OUT_KNOWN   = 2'd1;
  localparam logic [CODE_W-1:0] OUT_NEW     = 2'd2;
  localparam logic [CODE_W-1:0] OUT_FULL    = 2'd3;

  localparam logic [CODE_W-1:0] LEVEL_LOW    = 2'd0;
  localparam logic [CODE_W-1:0] LEVEL_MEDIUM = 2'd1;
  localparam logic [CODE_W-1:0] LEVEL_HIGH   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_RSSI_THRESHOLD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_SIGNAL_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXPIRE_MS        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RECENT_MS        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_Q8        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MEDIUM_THRESHOLD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD   = 3'd6;

  localparam logic signed [SIG_W-1:0] RSSI_THRESHOLD_RST   = -8'sd70;
  localparam logic signed [SIG_W-1:0] LOW_SIGNAL_LIMIT_RST = -8'sd60;
  localparam logic [TIME_W-1:0]       EXPIRE_MS_RST        = 32'd300000;
  localparam logic [TIME_W-1:0]       RECENT_MS_RST        = 32'd30000;
  localparam logic [WEIGHT_W-1:0]     WEIGHT_Q8_RST        = 16'd256;
  localparam logic [RISK_W-1:0]       MEDIUM_THRESHOLD_RST = 31'd9600;
  localparam logic [RISK_W-1:0]       HIGH_THRESHOLD_RST   = 31'd15600;

  typedef struct packed {
    logic                    valid;
    logic                    fresh;
    logic signed [SIG_W-1:0] signal;
    logic [TIME_W-1:0]       time_ms;
    logic [ADDR_W-1:0]       addr;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/mtarc_if.sv =====
`default_nettype none

interface mtarc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [mtarc_pkg::ADDR_W-1:0]           source_address;
  logic signed [mtarc_pkg::SIG_W-1:0]     signal_dbm;
  logic [mtarc_pkg::TIME_W-1:0]           now_ms;

  modport source (output valid, source_address, signal_dbm, now_ms, input ready);
  modport sink   (input valid, source_address, signal_dbm, now_ms, output ready);
endinterface

interface mtarc_out_if;
  logic                           valid;
  logic                           ready;
  logic [mtarc_pkg::CODE_W-1:0]   outcome;
  logic [mtarc_pkg::RISK_W-1:0]   risk_total;
  logic [mtarc_pkg::CODE_W-1:0]   risk_level;

  modport source (output valid, outcome, risk_total, risk_level, input ready);
  modport sink   (input valid, outcome, risk_total, risk_level, output ready);
endinterface

`default_nettype wire

// ===== sv/mac_table_aging_risk_counter_top.sv =====
`default_nettype none

// Contact-risk counter over a table of recently heard source addresses. Each input transfer is
// one received frame; each frame yields exactly one output transfer with its outcome, the risk
// total and its level. The table lives in one memory (one write and one registered read port)
// and every frame above the signal threshold walks it one entry per cycle; a frame at or below
// the threshold skips the table. For a known address the lookup walk stops at the hit; a new
// address takes the lookup walk, then a walk that frees expired entries, inserts and counts
// recent contacts, then a multiply and an add (a full table inserts nothing and skips both).
// After reset the block clears every table entry before it takes its first frame;
// register writes are taken during that time. Registers sit at byte address 4 * index: 0 signal
// threshold, 1 low-signal limit, 2 expiry age, 3 recent window, 4 Q8.8 weight, 5 medium and
// 6 high level thresholds.
module mac_table_aging_risk_counter_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mtarc_in_if.sink                               in_ch,
  mtarc_out_if.source                            out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mtarc_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [mtarc_pkg::DATA_W-1:0]      pwdata,
  output logic      [mtarc_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready
);

  import mtarc_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PROD_W  = CNT_W + WEIGHT_W;
  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic signed [SIG_W-1:0] rssi_thr_q, low_lim_q;
  logic [TIME_W-1:0]       expire_q, recent_q;
  logic [WEIGHT_W-1:0]     weight_q;
  logic [RISK_W-1:0]       med_thr_q, high_thr_q;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    cfg_idx;

  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic                    iss_q, iss_d;
  logic                    rd_en_q, rd_en_d;
  logic [IDX_W-1:0]        chk_idx_q, chk_idx_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic                    slot_ok_q, slot_ok_d;
  logic [CNT_W-1:0]        weak_q, weak_d, strong_q, strong_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [RISK_W-1:0]       risk_q, risk_d;
  logic [CODE_W-1:0]       outcome_q, outcome_d;
  logic                    out_valid_q, out_valid_d;
  logic [CODE_W-1:0]       out_outcome_q, out_outcome_d;
  logic [RISK_W-1:0]       out_total_q, out_total_d;
  logic [CODE_W-1:0]       out_level_q, out_level_d;

  logic [ADDR_W-1:0]       addr_q;
  logic signed [SIG_W-1:0] sig_q;
  logic [TIME_W-1:0]       now_q;
  logic                    frame_take;

  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  wr_word, rd_word;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [TIME_W-1:0]       age;
  logic                    expired, recent, is_new, count_it;
  logic [RISK_W+1:0]       sum;
  logic [CODE_W-1:0]       level;

  mtarc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_RSSI_THRESHOLD:   prdata = {24'd0, rssi_thr_q};
      REG_LOW_SIGNAL_LIMIT: prdata = {24'd0, low_lim_q};
      REG_EXPIRE_MS:        prdata = expire_q;
      REG_RECENT_MS:        prdata = recent_q;
      REG_WEIGHT_Q8:        prdata = {16'd0, weight_q};
      REG_MEDIUM_THRESHOLD: prdata = {1'b0, med_thr_q};
      REG_HIGH_THRESHOLD:   prdata = {1'b0, high_thr_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_thr_q <= RSSI_THRESHOLD_RST;
      low_lim_q  <= LOW_SIGNAL_LIMIT_RST;
      expire_q   <= EXPIRE_MS_RST;
      recent_q   <= RECENT_MS_RST;
      weight_q   <= WEIGHT_Q8_RST;
      med_thr_q  <= MEDIUM_THRESHOLD_RST;
      high_thr_q <= HIGH_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RSSI_THRESHOLD:   rssi_thr_q <= pwdata[SIG_W-1:0];
        REG_LOW_SIGNAL_LIMIT: low_lim_q  <= pwdata[SIG_W-1:0];
        REG_EXPIRE_MS:        expire_q   <= pwdata[TIME_W-1:0];
        REG_RECENT_MS:        recent_q   <= pwdata[TIME_W-1:0];
        REG_WEIGHT_Q8:        weight_q   <= pwdata[WEIGHT_W-1:0];
        REG_MEDIUM_THRESHOLD: med_thr_q  <= pwdata[RISK_W-1:0];
        REG_HIGH_THRESHOLD:   high_thr_q <= pwdata[RISK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready       = (state_q == ST_IDLE);
  assign frame_take        = in_ch.valid && (state_q == ST_IDLE);
  assign out_ch.valid      = out_valid_q;
  assign out_ch.outcome    = out_outcome_q;
  assign out_ch.risk_total = out_total_q;
  assign out_ch.risk_level = out_level_q;

  assign rd_word = entry_t'(ram_rdata);
  assign age     = now_q - rd_word.time_ms;
  assign expired = age > expire_q;
  assign recent  = age < recent_q;
  assign is_new  = slot_ok_q && (chk_idx_q == slot_q);
  assign sum     = (RISK_W+2)'(risk_q) + (RISK_W+2)'(weak_q) + (RISK_W+2)'(prod_q >> 7);

  always_comb begin
    if (risk_q > high_thr_q) begin
      level = LEVEL_HIGH;
    end else if (risk_q >= med_thr_q) begin
      level = LEVEL_MEDIUM;
    end else begin
      level = LEVEL_LOW;
    end
  end

  always_comb begin
    state_d       = state_q;
    rd_idx_d      = rd_idx_q;
    iss_d         = iss_q;
    rd_en_d       = 1'b0;
    chk_idx_d     = chk_idx_q;
    slot_d        = slot_q;
    slot_ok_d     = slot_ok_q;
    weak_d        = weak_q;
    strong_d      = strong_q;
    prod_d        = prod_q;
    risk_d        = risk_q;
    outcome_d     = outcome_q;
    out_valid_d   = out_valid_q;
    out_outcome_d = out_outcome_q;
    out_total_d   = out_total_q;
    out_level_d   = out_level_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = chk_idx_q;
    wr_word       = '0;
    count_it      = 1'b0;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    if ((state_q == ST_LOOK || state_q == ST_SWEEP) && iss_q) begin
      ram_re    = 1'b1;
      rd_en_d   = 1'b1;
      chk_idx_d = rd_idx_q;
      if (rd_idx_q == LAST_IDX) begin
        iss_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_q;
        if (rd_idx_q == LAST_IDX) begin
          rd_idx_d = '0;
          state_d  = ST_IDLE;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.signal_dbm > rssi_thr_q) begin
            rd_idx_d  = '0;
            iss_d     = 1'b1;
            slot_ok_d = 1'b0;
            state_d   = ST_LOOK;
          end else begin
            outcome_d = OUT_IGNORED;
            state_d   = ST_FIN;
          end
        end
      end
      ST_LOOK: begin
        if (rd_en_q) begin
          if (rd_word.valid && rd_word.addr == addr_q) begin
            wr_word = '{valid: 1'b1, fresh: 1'b0, signal: rd_word.signal,
                        time_ms: now_q, addr: addr_q};
            ram_we    = 1'b1;
            outcome_d = OUT_KNOWN;
            iss_d     = 1'b0;
            rd_en_d   = 1'b0;
            state_d   = ST_FIN;
          end else begin
            if (!slot_ok_q && (!rd_word.valid || expired)) begin
              slot_d    = chk_idx_q;
              slot_ok_d = 1'b1;
            end
            if (chk_idx_q == LAST_IDX) begin
              rd_idx_d = '0;
              iss_d    = 1'b1;
              weak_d   = '0;
              strong_d = '0;
              state_d  = ST_SWEEP;
            end
          end
        end
      end
      ST_SWEEP: begin
        if (rd_en_q) begin
          ram_we = 1'b1;
          if (is_new) begin
            wr_word = '{valid: 1'b1, fresh: 1'b1, signal: sig_q,
                        time_ms: now_q, addr: addr_q};
            count_it = (recent_q != '0);
          end else begin
            wr_word       = rd_word;
            wr_word.valid = rd_word.valid && !expired;
            count_it      = wr_word.valid && rd_word.fresh && recent;
          end
          if (count_it) begin
            if (wr_word.signal < low_lim_q) begin
              weak_d = weak_q + 1'b1;
            end else begin
              strong_d = strong_q + 1'b1;
            end
          end
          if (chk_idx_q == LAST_IDX) begin
            if (slot_ok_q) begin
              outcome_d = OUT_NEW;
              state_d   = ST_MUL;
            end else begin
              outcome_d = OUT_FULL;
              state_d   = ST_FIN;
            end
          end
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(strong_q) * PROD_W'(weight_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (sum > (RISK_W+2)'(RISK_MAX)) begin
          risk_d = RISK_MAX;
        end else begin
          risk_d = sum[RISK_W-1:0];
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d   = 1'b1;
          out_outcome_d = outcome_q;
          out_total_d   = risk_q;
          out_level_d   = level;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rd_idx_q    <= '0;
      iss_q       <= 1'b0;
      rd_en_q     <= 1'b0;
      chk_idx_q   <= '0;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      weak_q      <= '0;
      strong_q    <= '0;
      risk_q      <= '0;
      outcome_q   <= OUT_IGNORED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      iss_q       <= iss_d;
      rd_en_q     <= rd_en_d;
      chk_idx_q   <= chk_idx_d;
      slot_q      <= slot_d;
      slot_ok_q   <= slot_ok_d;
      weak_q      <= weak_d;
      strong_q    <= strong_d;
      risk_q      <= risk_d;
      outcome_q   <= outcome_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q        <= prod_d;
    out_outcome_q <= out_outcome_d;
    out_total_q   <= out_total_d;
    out_level_q   <= out_level_d;
    if (frame_take) begin
      addr_q <= in_ch.source_address;
      sig_q  <= in_ch.signal_dbm;
      now_q  <= in_ch.now_ms;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtarc_ram.sv =====
`default_nettype none

module mtarc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtarc_checker.sv =====
`default_nettype none

module mtarc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [mtarc_pkg::CODE_W-1:0]    outcome_i,
  input wire logic [mtarc_pkg::RISK_W-1:0]    risk_total_i,
  input wire logic [mtarc_pkg::CODE_W-1:0]    risk_level_i
);

  import mtarc_pkg::*;

  logic [RISK_W-1:0] last_total_q;
  logic              out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_xfer) begin
      last_total_q <= risk_total_i;
    end
  end

  // The block works on one frame at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(outcome_i)
      && $stable(risk_total_i) && $stable(risk_level_i))
    else $error("stalled result changed");

  // Only an inserted frame may change the total, and then only upward.
  a_total_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && outcome_i != OUT_NEW |-> risk_total_i == last_total_q)
    else $error("risk total changed without an insert");

  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && outcome_i == OUT_NEW |-> risk_total_i >= last_total_q)
    else $error("risk total decreased");

endmodule

bind mac_table_aging_risk_counter_top mtarc_checker u_mtarc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .outcome_i    (out_ch.outcome),
  .risk_total_i (out_ch.risk_total),
  .risk_level_i (out_ch.risk_level)
);

`default_nettype wire
